// ----- hdl/ngsc_pkg.sv -----
// shared constants, codes and character tables for the gsv satellite counter
`timescale 1ns / 1ps
package ngsc_pkg;

	localparam logic       OP_BYTE       = 1'b0;
	localparam logic       OP_TICK       = 1'b1;

	localparam logic [2:0] STAGE_IDLE    = 3'd0;
	localparam logic [2:0] STAGE_CAPTURE = 3'd6;

	localparam logic [1:0] KIND_NONE     = 2'd0;
	localparam logic [1:0] KIND_BD       = 2'd1;
	localparam logic [1:0] KIND_GP       = 2'd2;
	localparam logic [1:0] KIND_ANY      = 2'd3;

	localparam logic [2:0] COMMA_FIELD   = 3'd3;
	localparam logic [2:0] COMMA_MAX     = 3'd4;
	localparam logic [7:0] KIND_END_POS  = 8'd6;

	localparam logic [7:0] CHR_DOLLAR    = 8'h24;
	localparam logic [7:0] CHR_COMMA     = 8'h2c;
	localparam logic [7:0] CHR_NEWLINE   = 8'h0a;
	localparam logic [7:0] CHR_ZERO      = 8'h30;
	localparam logic [7:0] CHR_NINE      = 8'h39;
	localparam logic [7:0] IDLE_LIMIT_RST = 8'd1;

	// "$GNRMC"
	function automatic logic [7:0] header_char(input logic [2:0] idx);
		logic [7:0] ch;
		case (idx)
			3'd0:    ch = 8'h24;
			3'd1:    ch = 8'h47;
			3'd2:    ch = 8'h4e;
			3'd3:    ch = 8'h52;
			3'd4:    ch = 8'h4d;
			3'd5:    ch = 8'h43;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// "$BDGSV"
	function automatic logic [7:0] bd_char(input logic [2:0] idx);
		logic [7:0] ch;
		case (idx)
			3'd0:    ch = 8'h24;
			3'd1:    ch = 8'h42;
			3'd2:    ch = 8'h44;
			3'd3:    ch = 8'h47;
			3'd4:    ch = 8'h53;
			3'd5:    ch = 8'h56;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// "$GPGSV"
	function automatic logic [7:0] gp_char(input logic [2:0] idx);
		logic [7:0] ch;
		case (idx)
			3'd0:    ch = 8'h24;
			3'd1:    ch = 8'h47;
			3'd2:    ch = 8'h50;
			3'd3:    ch = 8'h47;
			3'd4:    ch = 8'h53;
			3'd5:    ch = 8'h56;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

// ----- hdl/ngsc_in_if.sv -----
// request channel: byte or tick
`timescale 1ns / 1ps
interface ngsc_in_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [7:0] rx_byte;

	modport source (output valid, output operation, output rx_byte, input ready);
	modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

// ----- hdl/ngsc_out_if.sv -----
// result channel: header stage, line flag, satellite counts, burst end
`timescale 1ns / 1ps
interface ngsc_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] header_stage;
	logic       line_done;
	logic [6:0] beidou_sats;
	logic [6:0] gps_sats;
	logic [7:0] total_sats;
	logic       burst_end;

	modport source (output valid, output header_stage, output line_done,
		output beidou_sats, output gps_sats, output total_sats, output burst_end,
		input ready);
	modport sink   (input valid, input header_stage, input line_done,
		input beidou_sats, input gps_sats, input total_sats, input burst_end,
		output ready);
endinterface

// ----- hdl/nmea_gsv_satellite_counter_core.sv -----
// top level: nmea gsv satellite counter, one request in, one result out
//
//   channel   dir   handshake      payload
//   item      in    valid/ready    operation, rx_byte
//   result    out   valid/ready    header_stage, line_done, beidou_sats,
//                                  gps_sats, total_sats, burst_end
//   cfg       in    cfg_we         cfg_wdata (idle_limit)
//
// a request is registered in the input register, then parsed combinationally
// into the result register; one request per cycle sustained while result.ready is high
// a stalled result holds the result register; one more request fills the
// input register, then item.ready drops until result.ready returns
// arst_n clears parser state, idle_limit returns to 1, no clearing pass
`timescale 1ns / 1ps
module nmea_gsv_satellite_counter_core #(
	parameter int LINE_SLOTS  = 8,
	parameter int LINE_LENGTH = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	ngsc_in_if.sink           item,
	ngsc_out_if.source        result,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_wdata
);
	import ngsc_pkg::*;

	localparam int                SLOT_W    = (LINE_SLOTS > 1) ? $clog2(LINE_SLOTS) : 1;
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(LINE_SLOTS - 1);
	localparam logic [7:0]        POS_LIMIT = 8'(LINE_LENGTH - 1);

	// input register
	logic       valid_s1;
	logic       op_s1;
	logic [7:0] byte_s1;
	logic       take_s1;

	// parser state
	logic [7:0]        idle_limit_q;
	logic [2:0]        stage_q,   stage_d;
	logic [SLOT_W-1:0] slot_q,    slot_d;
	logic [7:0]        pos_q,     pos_d;
	logic [1:0]        kind_q,    kind_d;
	logic              dollar_q,  dollar_d;
	logic [2:0]        comma_q,   comma_d;
	logic [1:0]        flen_q,    flen_d;
	logic [3:0]        dhigh_q,   dhigh_d;
	logic [3:0]        dlow_q,    dlow_d;
	logic              fok_q,     fok_d;
	logic              bfound_q,  bfound_d;
	logic              gfound_q,  gfound_d;
	logic [6:0]        bcount_q,  bcount_d;
	logic [6:0]        gcount_q,  gcount_d;
	logic [7:0]        idle_q,    idle_d;
	logic              done_d;

	// result register
	logic       res_valid_q;
	logic [2:0] res_stage_q;
	logic       res_done_q;
	logic [6:0] res_bd_q;
	logic [6:0] res_gp_q;
	logic [7:0] res_total_q;
	logic       res_burst_q;

	logic       is_digit;
	logic [3:0] digit;
	logic       fv_ok;
	logic [6:0] fv;

	assign take_s1    = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || take_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (take_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			op_s1   <= item.operation;
			byte_s1 <= item.rx_byte;
		end
	end

	assign is_digit = (byte_s1 >= CHR_ZERO) && (byte_s1 <= CHR_NINE);
	assign digit    = is_digit ? 4'(byte_s1 - CHR_ZERO) : 4'd0;
	assign fv_ok    = dollar_q && (comma_q >= COMMA_MAX) && (flen_q != 2'd0) && fok_q;
	assign fv       = (flen_q == 2'd1) ? 7'(dhigh_q)
		: 7'({dhigh_q, 3'b000}) + 7'({dhigh_q, 1'b0}) + 7'(dlow_q);

	always_comb begin
		stage_d  = stage_q;
		slot_d   = slot_q;
		pos_d    = pos_q;
		kind_d   = kind_q;
		dollar_d = dollar_q;
		comma_d  = comma_q;
		flen_d   = flen_q;
		dhigh_d  = dhigh_q;
		dlow_d   = dlow_q;
		fok_d    = fok_q;
		bfound_d = bfound_q;
		gfound_d = gfound_q;
		bcount_d = bcount_q;
		gcount_d = gcount_q;
		idle_d   = idle_q;
		done_d   = 1'b0;

		if (op_s1 == OP_TICK) begin
			if (idle_q != 8'hff) begin
				idle_d = idle_q + 8'd1;
			end
		end else begin
			idle_d = 8'd0;
			if (stage_q < STAGE_CAPTURE) begin
				if (byte_s1 == header_char(stage_q)) begin
					stage_d = stage_q + 3'd1;
					pos_d   = 8'(stage_d);
					if (stage_d == STAGE_CAPTURE) begin
						kind_d   = KIND_NONE;
						dollar_d = 1'b1;
						comma_d  = 3'd0;
						flen_d   = 2'd0;
						fok_d    = 1'b0;
					end
				end else begin
					stage_d  = STAGE_IDLE;
					pos_d    = 8'd0;
					slot_d   = '0;
					bfound_d = 1'b0;
					gfound_d = 1'b0;
				end
			end else if (byte_s1 == CHR_NEWLINE) begin
				done_d = 1'b1;
				if (slot_q != SLOT_LAST && pos_q >= KIND_END_POS) begin
					if (kind_q == KIND_BD && !bfound_q) begin
						bfound_d = 1'b1;
						if (fv_ok) begin
							bcount_d = fv;
						end
					end else if (kind_q == KIND_GP && !gfound_q) begin
						gfound_d = 1'b1;
						if (fv_ok) begin
							gcount_d = fv;
						end
					end
				end
				if (slot_q == SLOT_LAST) begin
					slot_d   = '0;
					bfound_d = 1'b0;
					gfound_d = 1'b0;
				end else begin
					slot_d = slot_q + 1'b1;
				end
				pos_d = 8'd0;
			end else if (pos_q < POS_LIMIT) begin
				if (pos_q == 8'd0) begin
					dollar_d = (byte_s1 == CHR_DOLLAR);
					kind_d   = KIND_ANY;
					comma_d  = 3'd0;
					flen_d   = 2'd0;
					dhigh_d  = 4'd0;
					dlow_d   = 4'd0;
					fok_d    = 1'b1;
				end else begin
					if (pos_q < KIND_END_POS) begin
						if (byte_s1 != bd_char(pos_q[2:0])) begin
							kind_d[0] = 1'b0;
						end
						if (byte_s1 != gp_char(pos_q[2:0])) begin
							kind_d[1] = 1'b0;
						end
					end
					if (byte_s1 == CHR_COMMA) begin
						if (comma_q < COMMA_MAX) begin
							comma_d = comma_q + 3'd1;
						end
					end else if (comma_q == COMMA_FIELD) begin
						if (flen_q == 2'd0) begin
							dhigh_d = digit;
							flen_d  = 2'd1;
							if (!is_digit) begin
								fok_d = 1'b0;
							end
						end else if (flen_q == 2'd1) begin
							dlow_d = digit;
							flen_d = 2'd2;
							if (!is_digit) begin
								fok_d = 1'b0;
							end
						end
					end
				end
				pos_d = pos_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_limit_q <= IDLE_LIMIT_RST;
		end else if (cfg_we) begin
			idle_limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q  <= STAGE_IDLE;
			slot_q   <= '0;
			pos_q    <= 8'd0;
			kind_q   <= KIND_NONE;
			dollar_q <= 1'b0;
			comma_q  <= 3'd0;
			flen_q   <= 2'd0;
			dhigh_q  <= 4'd0;
			dlow_q   <= 4'd0;
			fok_q    <= 1'b0;
			bfound_q <= 1'b0;
			gfound_q <= 1'b0;
			bcount_q <= 7'd0;
			gcount_q <= 7'd0;
			idle_q   <= 8'd0;
		end else if (take_s1) begin
			stage_q  <= stage_d;
			slot_q   <= slot_d;
			pos_q    <= pos_d;
			kind_q   <= kind_d;
			dollar_q <= dollar_d;
			comma_q  <= comma_d;
			flen_q   <= flen_d;
			dhigh_q  <= dhigh_d;
			dlow_q   <= dlow_d;
			fok_q    <= fok_d;
			bfound_q <= bfound_d;
			gfound_q <= gfound_d;
			bcount_q <= bcount_d;
			gcount_q <= gcount_d;
			idle_q   <= idle_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take_s1) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			res_stage_q <= stage_d;
			res_done_q  <= done_d;
			res_bd_q    <= bcount_d;
			res_gp_q    <= gcount_d;
			res_total_q <= 8'(bcount_d) + 8'(gcount_d);
			res_burst_q <= (stage_d == STAGE_CAPTURE) && (idle_d > idle_limit_q);
		end
	end

	assign result.valid        = res_valid_q;
	assign result.header_stage = res_stage_q;
	assign result.line_done    = res_done_q;
	assign result.beidou_sats  = res_bd_q;
	assign result.gps_sats     = res_gp_q;
	assign result.total_sats   = res_total_q;
	assign result.burst_end    = res_burst_q;

endmodule

// ----- hdl/ngsc_checker.sv -----
// port-level checks for the gsv satellite counter, bound to the top level
`timescale 1ns / 1ps
module ngsc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [2:0] header_stage,
	input logic       line_done,
	input logic [6:0] beidou_sats,
	input logic [6:0] gps_sats,
	input logic [7:0] total_sats,
	input logic       burst_end
);
	import ngsc_pkg::*;

	a_total_sum: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (total_sats == (8'(beidou_sats) + 8'(gps_sats))))
		else $error("total_sats is not the sum of the two counts");

	a_burst_capture: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && burst_end) |-> (header_stage == STAGE_CAPTURE))
		else $error("burst_end outside line capture");

	a_done_capture: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && line_done) |-> (header_stage == STAGE_CAPTURE))
		else $error("line_done outside line capture");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(header_stage)
			&& $stable(beidou_sats) && $stable(gps_sats) && $stable(burst_end)))
		else $error("stalled result changed");

endmodule

bind nmea_gsv_satellite_counter_core ngsc_checker u_ngsc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (result.valid),
	.res_ready    (result.ready),
	.header_stage (result.header_stage),
	.line_done    (result.line_done),
	.beidou_sats  (result.beidou_sats),
	.gps_sats     (result.gps_sats),
	.total_sats   (result.total_sats),
	.burst_end    (result.burst_end)
);

// ----- bench/tb.sv -----
// self-checking bench for the gsv satellite counter: byte and tick requests against a predictor
`timescale 1ns / 1ps
module tb;
	import ngsc_pkg::*;

	localparam int LINE_SLOTS  = 8;
	localparam int LINE_LENGTH = 128;

	localparam logic [47:0] HEADER_TXT = "$GNRMC";
	localparam logic [47:0] BD_TXT     = "$BDGSV";
	localparam logic [47:0] GP_TXT     = "$GPGSV";

	typedef enum logic [1:0] {ACT_REQUEST, ACT_SET_LIMIT, ACT_DRAIN} plan_kind_t;

	typedef struct {
		plan_kind_t kind;
		logic       op;
		logic [7:0] data;
	} plan_entry_t;

	typedef struct packed {
		logic [2:0] header_stage;
		logic       line_done;
		logic [6:0] beidou_sats;
		logic [6:0] gps_sats;
		logic [7:0] total_sats;
		logic       burst_end;
	} sat_report_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [7:0] cfg_wdata;

	ngsc_in_if  item_bus ();
	ngsc_out_if res_bus ();

	nmea_gsv_satellite_counter_core #(
		.LINE_SLOTS (LINE_SLOTS),
		.LINE_LENGTH(LINE_LENGTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_bus),
		.result   (res_bus),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	plan_entry_t pending_requests[$];
	sat_report_t predicted_reports[$];

	// predictor state
	logic [7:0] idle_limit_q = IDLE_LIMIT_RST;
	logic [2:0] hdr_stage    = STAGE_IDLE;
	int         slot_idx     = 0;
	logic [7:0] char_pos     = 8'd0;
	logic [1:0] kind_mask    = KIND_NONE;
	logic       starts_dollar = 1'b0;
	logic [2:0] commas       = 3'd0;
	logic [1:0] fld_len      = 2'd0;
	logic [3:0] dig_hi       = 4'd0;
	logic [3:0] dig_lo       = 4'd0;
	logic       fld_ok       = 1'b0;
	logic       bd_seen      = 1'b0;
	logic       gp_seen      = 1'b0;
	logic [6:0] bd_count     = 7'd0;
	logic [6:0] gp_count     = 7'd0;
	logic [7:0] idle_ticks   = 8'd0;

	int error_count    = 0;
	int requests_taken = 0;
	int bytes_sent     = 0;
	int ticks_sent     = 0;
	int lines_seen     = 0;
	int bursts_seen    = 0;
	int limit_writes   = 0;
	int burst_left     = 1;
	int gap_left       = 0;
	int rx_mode        = 0;
	int mode_left      = 0;
	logic rx_toggle    = 1'b0;
	int hold_left;
	logic hold_armed;
	int plan_limit     = IDLE_LIMIT_RST;

	function automatic logic [7:0] text_char(input logic [47:0] txt, input int idx);
		return txt[47 - 8 * idx -: 8];
	endfunction

	function automatic logic field_value(output logic [6:0] val);
		val = 7'd0;
		if (!starts_dollar || commas != COMMA_MAX || fld_len == 2'd0 || !fld_ok)
			return 1'b0;
		if (fld_len == 2'd1)
			val = {3'b000, dig_hi};
		else
			val = {3'b000, dig_hi} * 7'd10 + {3'b000, dig_lo};
		return 1'b1;
	endfunction

	task automatic predict_report(input logic op, input logic [7:0] ch);
		sat_report_t r;
		logic [6:0] v;
		logic dig;
		r.line_done = 1'b0;
		if (op == OP_TICK) begin
			if (idle_ticks != 8'hff)
				idle_ticks = idle_ticks + 8'd1;
		end else begin
			idle_ticks = 8'd0;
			if (hdr_stage != STAGE_CAPTURE) begin
				if (ch == text_char(HEADER_TXT, hdr_stage)) begin
					hdr_stage = hdr_stage + 3'd1;
					char_pos = {5'd0, hdr_stage};
					if (hdr_stage == STAGE_CAPTURE) begin
						kind_mask = KIND_NONE;
						starts_dollar = 1'b1;
						commas = 3'd0;
						fld_len = 2'd0;
						fld_ok = 1'b0;
					end
				end else begin
					hdr_stage = STAGE_IDLE;
					char_pos = 8'd0;
					slot_idx = 0;
					bd_seen = 1'b0;
					gp_seen = 1'b0;
				end
			end else if (ch == CHR_NEWLINE) begin
				r.line_done = 1'b1;
				if (slot_idx != LINE_SLOTS - 1 && char_pos >= KIND_END_POS) begin
					if (kind_mask == KIND_BD && !bd_seen) begin
						bd_seen = 1'b1;
						if (field_value(v))
							bd_count = v;
					end else if (kind_mask == KIND_GP && !gp_seen) begin
						gp_seen = 1'b1;
						if (field_value(v))
							gp_count = v;
					end
				end
				if (slot_idx == LINE_SLOTS - 1) begin
					slot_idx = 0;
					bd_seen = 1'b0;
					gp_seen = 1'b0;
				end else begin
					slot_idx++;
				end
				char_pos = 8'd0;
			end else if (char_pos < LINE_LENGTH - 1) begin
				if (char_pos == 8'd0) begin
					starts_dollar = (ch == CHR_DOLLAR);
					kind_mask = KIND_ANY;
					commas = 3'd0;
					fld_len = 2'd0;
					dig_hi = 4'd0;
					dig_lo = 4'd0;
					fld_ok = 1'b1;
				end else begin
					if (char_pos < KIND_END_POS) begin
						if (ch != text_char(BD_TXT, char_pos))
							kind_mask &= KIND_GP;
						if (ch != text_char(GP_TXT, char_pos))
							kind_mask &= KIND_BD;
					end
					if (ch == CHR_COMMA) begin
						if (commas < COMMA_MAX)
							commas = commas + 3'd1;
					end else if (commas == COMMA_FIELD) begin
						dig = (ch >= CHR_ZERO && ch <= CHR_NINE);
						if (fld_len == 2'd0) begin
							dig_hi = dig ? ch[3:0] : 4'd0;
							fld_len = 2'd1;
							if (!dig)
								fld_ok = 1'b0;
						end else if (fld_len == 2'd1) begin
							dig_lo = dig ? ch[3:0] : 4'd0;
							fld_len = 2'd2;
							if (!dig)
								fld_ok = 1'b0;
						end
					end
				end
				char_pos = char_pos + 8'd1;
			end
		end
		r.header_stage = hdr_stage;
		r.beidou_sats = bd_count;
		r.gps_sats = gp_count;
		r.total_sats = {1'b0, bd_count} + {1'b0, gp_count};
		r.burst_end = (hdr_stage == STAGE_CAPTURE) && (idle_ticks > idle_limit_q);
		predicted_reports.push_back(r);
	endtask

	function automatic string report_text(input sat_report_t r);
		return $sformatf("stage %0d done %0d bd %0d gp %0d total %0d end %0d",
			r.header_stage, r.line_done, r.beidou_sats, r.gps_sats, r.total_sats,
			r.burst_end);
	endfunction

	task automatic flag_error(input string msg);
		error_count++;
		if (error_count <= 10)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// stimulus plan helpers
	task automatic push_request(input logic op, input logic [7:0] b);
		pending_requests.push_back('{ACT_REQUEST, op, b});
	endtask

	task automatic push_line_byte(input logic [7:0] b, input logic sprinkle);
		push_request(OP_BYTE, b);
		if (sprinkle && $urandom_range(0, 29) == 0)
			push_request(OP_TICK, 8'($urandom_range(0, 255)));
	endtask

	task automatic push_text(input string s, input logic sprinkle);
		for (int i = 0; i < s.len(); i++)
			push_line_byte(s[i], sprinkle);
	endtask

	task automatic push_ticks(input int n);
		for (int i = 0; i < n; i++)
			push_request(OP_TICK, 8'($urandom_range(0, 255)));
	endtask

	task automatic push_limit(input logic [7:0] v);
		pending_requests.push_back('{ACT_DRAIN, OP_BYTE, 8'd0});
		pending_requests.push_back('{ACT_SET_LIMIT, OP_BYTE, v});
		plan_limit = v;
	endtask

	function automatic logic [7:0] non_digit();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if (b >= CHR_ZERO && b <= CHR_NINE)
			b = b + 8'h40;
		return b;
	endfunction

	task automatic push_random_line();
		int pick;
		int n;
		string s;
		pick = $urandom_range(0, 99);
		if (pick < 34) begin
			push_text("$BDGSV", 1'b1);
		end else if (pick < 68) begin
			push_text("$GPGSV", 1'b1);
		end else if (pick < 74) begin
			push_text("$GNGSA", 1'b1);
		end else if (pick < 80) begin
			push_text($urandom_range(0, 1) ? "XBDGSV" : "*GPGSV", 1'b1);
		end else if (pick < 86) begin
			if ($urandom_range(0, 1))
				push_text("$BDGS", 1'b1);
			else
				push_text("$G", 1'b1);
			push_line_byte(CHR_NEWLINE, 1'b1);
			return;
		end else if (pick < 93) begin
			s = $urandom_range(0, 1) ? "$BDGSV" : "$GPGSV";
			s.putc($urandom_range(1, 5), "Q");
			push_text(s, 1'b1);
		end else begin
			n = $urandom_range(1, 12);
			for (int i = 0; i < n; i++)
				push_line_byte(8'($urandom_range(0, 255)), 1'b1);
			push_line_byte(CHR_NEWLINE, 1'b1);
			return;
		end
		if ($urandom_range(0, 9) == 0)
			push_text(",3,", 1'b1);
		else
			push_text(",3,1,", 1'b1);
		pick = $urandom_range(0, 99);
		if (pick < 25) begin
			push_line_byte(CHR_ZERO + 8'($urandom_range(0, 9)), 1'b1);
		end else if (pick < 65) begin
			n = (pick < 55) ? 2 : 3;
			for (int i = 0; i < n; i++)
				push_line_byte(CHR_ZERO + 8'($urandom_range(0, 9)), 1'b1);
		end else if (pick < 75) begin
			// empty field
		end else if (pick < 85) begin
			push_line_byte(CHR_ZERO + 8'($urandom_range(0, 9)), 1'b1);
			push_line_byte(non_digit(), 1'b1);
		end else if (pick < 95) begin
			push_line_byte(non_digit(), 1'b1);
			push_line_byte(CHR_ZERO + 8'($urandom_range(0, 9)), 1'b1);
		end else begin
			push_line_byte(8'($urandom_range(0, 255)), 1'b1);
		end
		pick = $urandom_range(0, 9);
		if (pick < 6)
			push_text(",10,045,30", 1'b1);
		else if (pick < 8)
			push_text(",", 1'b1);
		push_line_byte(CHR_NEWLINE, 1'b1);
	endtask

	task automatic push_long_line();
		push_text("$BDGSV,1,1,9,", 1'b0);
		for (int i = 0; i < 130; i++)
			push_line_byte(8'($urandom_range(8'h61, 8'h7a)), 1'b0);
		push_line_byte(CHR_NEWLINE, 1'b0);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin : driver
		logic nxt_valid;
		logic nxt_we;
		plan_entry_t head;
		if (!arst_n) begin
			item_bus.valid <= 1'b0;
			item_bus.operation <= OP_BYTE;
			item_bus.rx_byte <= 8'd0;
			cfg_we <= 1'b0;
			cfg_wdata <= 8'd0;
		end else begin
			nxt_we = 1'b0;
			if (item_bus.valid && item_bus.ready) begin
				predict_report(item_bus.operation, item_bus.rx_byte);
				requests_taken++;
				if (item_bus.operation == OP_TICK)
					ticks_sent++;
				else
					bytes_sent++;
			end
			if (!item_bus.valid || item_bus.ready) begin
				nxt_valid = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_requests.size() > 0) begin
					head = pending_requests[0];
					case (head.kind)
						ACT_REQUEST: begin
							void'(pending_requests.pop_front());
							nxt_valid = 1'b1;
							item_bus.operation <= head.op;
							item_bus.rx_byte <= head.data;
							burst_left--;
							if (burst_left <= 0) begin
								if ($urandom_range(0, 5) == 0) begin
									burst_left = $urandom_range(40, 120);
									gap_left = 0;
								end else begin
									burst_left = $urandom_range(1, 12);
									gap_left = $urandom_range(1, 6);
								end
							end
						end
						ACT_SET_LIMIT: begin
							if (predicted_reports.size() == 0) begin
								void'(pending_requests.pop_front());
								nxt_we = 1'b1;
								cfg_wdata <= head.data;
								idle_limit_q = head.data;
								limit_writes++;
							end
						end
						default: begin
							if (predicted_reports.size() == 0)
								void'(pending_requests.pop_front());
						end
					endcase
				end
				item_bus.valid <= nxt_valid;
			end
			cfg_we <= nxt_we;
		end
	end

	// long receiver hold-off, once
	always @(posedge clk or negedge arst_n) begin : hold_proc
		if (!arst_n) begin
			hold_left <= 0;
			hold_armed <= 1'b1;
		end else if (hold_armed && requests_taken >= 350) begin
			hold_left <= 200;
			hold_armed <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin : monitor
		sat_report_t got;
		sat_report_t want;
		logic nxt_ready;
		if (!arst_n) begin
			res_bus.ready <= 1'b0;
		end else begin
			if (res_bus.valid && res_bus.ready) begin
				got.header_stage = res_bus.header_stage;
				got.line_done = res_bus.line_done;
				got.beidou_sats = res_bus.beidou_sats;
				got.gps_sats = res_bus.gps_sats;
				got.total_sats = res_bus.total_sats;
				got.burst_end = res_bus.burst_end;
				if (predicted_reports.size() == 0) begin
					flag_error({"unexpected result: ", report_text(got)});
				end else begin
					want = predicted_reports.pop_front();
					if (got !== want)
						flag_error({"expected ", report_text(want), ", got ",
							report_text(got)});
				end
				if (got.line_done === 1'b1)
					lines_seen++;
				if (got.burst_end === 1'b1)
					bursts_seen++;
			end
			if (mode_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 150);
			end else begin
				mode_left--;
			end
			case (rx_mode)
				0: nxt_ready = 1'b1;
				1: begin
					nxt_ready = rx_toggle;
					rx_toggle = ~rx_toggle;
				end
				2: nxt_ready = $urandom_range(0, 1);
				default: nxt_ready = ($urandom_range(0, 5) == 0);
			endcase
			res_bus.ready <= nxt_ready && (hold_left == 0);
		end
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d requests still queued", pending_requests.size());
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		int limits [6];
		int start;
		item_bus.valid = 1'b0;
		item_bus.operation = OP_BYTE;
		item_bus.rx_byte = 8'd0;
		res_bus.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 8'd0;
		arst_n = 1'b0;

		// header hunt: tick, broken prefix, a dollar that is not retried
		push_ticks(1);
		push_request(OP_BYTE, 8'hff);
		push_text("$GNx", 1'b0);
		push_text("$$", 1'b0);
		push_text("$GNRMC", 1'b0);
		push_line_byte(CHR_NEWLINE, 1'b0);
		push_ticks(2);
		push_text("$BDGSV,,,7,", 1'b0);
		push_line_byte(CHR_NEWLINE, 1'b0);
		push_text("$GPGSV,,,42,", 1'b0);
		push_line_byte(CHR_NEWLINE, 1'b0);

		limits[0] = 0;
		limits[1] = 255;
		limits[2] = 1;
		limits[3] = $urandom_range(2, 12);
		limits[4] = $urandom_range(0, 255);
		limits[5] = 3;
		for (int ph = 0; ph < 6; ph++) begin
			push_limit(8'(limits[ph]));
			start = pending_requests.size();
			if (ph == 1)
				push_ticks(260);
			if (ph == 2 || ph == 4)
				push_long_line();
			while (pending_requests.size() - start < 60) begin
				push_random_line();
				if ($urandom_range(0, 3) == 0)
					push_ticks($urandom_range(0, plan_limit < 6 ? plan_limit + 3 : 8));
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_requests.size() != 0 || item_bus.valid)
			@(posedge clk);
		while (predicted_reports.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (predicted_reports.size() != 0)
			flag_error($sformatf("%0d results never arrived", predicted_reports.size()));

		$display("covered %0d bytes and %0d ticks, %0d completed lines, %0d burst-end results",
			bytes_sent, ticks_sent, lines_seen, bursts_seen);
		$display("idle limit written %0d times, %0d failures", limit_writes, error_count);
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
